[sv/trilateration_2d_solver_macros.svh]
// Assertion macros shared by the trilateration solver.
// Depends on a clock named clk and an active-low reset named rst_n in the including scope.
`ifndef TRILATERATION_2D_SOLVER_MACROS_SVH
`define TRILATERATION_2D_SOLVER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define TRI2D_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("trilateration solver: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define TRI2D_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("trilateration solver: next-cycle check failed");

`endif

[sv/tri2d_pkg.sv]
// Shared widths, codes and control types for the trilateration solver.
// No dependencies; the other source files, apart from the macro header, refer to it by scoped names.
package tri2d_pkg;

    localparam int W_CRD  = 32;
    localparam int W_DIST = 31;
    localparam int W_CNT  = 6;
    localparam int W_DIFF = 34;
    localparam int W_SQ   = 64;
    localparam int W_CF   = 65;
    localparam int W_PP   = 67;
    localparam int W_PROD = 98;
    localparam int W_NUM  = 99;
    localparam int W_DET  = 68;
    localparam int W_ABSN = 98;
    localparam int W_N    = 101;
    localparam int W_DV   = 69;
    localparam int Q_BITS = 32;

    localparam int DIV_LAT   = Q_BITS + 4;
    localparam int TOTAL_LAT = DIV_LAT + 8;

    localparam logic [W_CNT-1:0] MIN_REFERENCES = 6'd3;
    localparam logic [W_CRD-1:0] COORD_MAX = 32'h7FFF_FFFF;
    localparam logic [W_CRD-1:0] COORD_MIN = 32'h8000_0000;

    typedef enum logic [1:0] {
        ST_SOLVED    = 2'd0,
        ST_FEW       = 2'd1,
        ST_SINGULAR  = 2'd2,
        ST_SATURATED = 2'd3
    } status_t;

    typedef struct packed {
        logic valid;
        logic few;
        logic sing;
    } ctrl_t;

endpackage

[sv/trilateration_2d_solver.sv]
// Two-dimensional trilateration solver, fully pipelined: one request per clock, never busy.
// A request accepted at a rising edge passes the front end, the dividers and the output register
// before done marks its result; the 32-stage quotient pipeline is the longest part of that path.
// Throughput: one result per cycle; the receiver cannot stall, so nothing ever backs up.
// Reset (rst_n, asynchronous, active low) clears every valid bit; data registers are not reset.
// Depends on tri2d_pkg, tri2d_front, tri2d_div and trilateration_2d_solver_macros.svh.
`include "trilateration_2d_solver_macros.svh"

module trilateration_2d_solver
#(
    parameter logic [tri2d_pkg::W_CNT-1:0] MIN_REFERENCES = tri2d_pkg::MIN_REFERENCES
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [tri2d_pkg::W_CRD-1:0]  ref0_x,
    input  logic signed [tri2d_pkg::W_CRD-1:0]  ref0_y,
    input  logic        [tri2d_pkg::W_DIST-1:0] dist0,
    input  logic signed [tri2d_pkg::W_CRD-1:0]  ref1_x,
    input  logic signed [tri2d_pkg::W_CRD-1:0]  ref1_y,
    input  logic        [tri2d_pkg::W_DIST-1:0] dist1,
    input  logic signed [tri2d_pkg::W_CRD-1:0]  ref2_x,
    input  logic signed [tri2d_pkg::W_CRD-1:0]  ref2_y,
    input  logic        [tri2d_pkg::W_DIST-1:0] dist2,
    input  logic        [tri2d_pkg::W_CNT-1:0]  reference_count,
    output logic                                done,
    output logic signed [tri2d_pkg::W_CRD-1:0]  pos_x,
    output logic signed [tri2d_pkg::W_CRD-1:0]  pos_y,
    output logic        [1:0]                   status
);

    localparam int DIV_LAT = tri2d_pkg::DIV_LAT;

    // The front end forms the two linear equations A*x + B*y = C and D*x + E*y = F from the
    // pairwise differences of the circle equations, then the determinant A*E - B*D and the
    // Cramer numerators C*E - F*B and A*F - C*D, all exact.
    tri2d_pkg::ctrl_t                   front_ctrl;
    logic signed [tri2d_pkg::W_NUM-1:0] num_x, num_y;
    logic signed [tri2d_pkg::W_DET-1:0] det;

    // Each coordinate has its own divider; both share the determinant.
    logic [tri2d_pkg::W_CRD-1:0] qx, qy;
    logic                        sat_x, sat_y;

    // Control flags ride alongside the dividers so that they line up with the quotients.
    tri2d_pkg::ctrl_t ctrl_dly_reg [0:DIV_LAT-1];
    tri2d_pkg::ctrl_t tail;

    logic                        done_reg, done_next;
    logic [tri2d_pkg::W_CRD-1:0] pos_x_reg, pos_x_next, pos_y_reg, pos_y_next;
    tri2d_pkg::status_t          status_reg, status_next;

    // A result that reports a rejected solve.
    logic                        reject_seen;

    // The pipeline takes a request every cycle.
    assign busy = 1'b0;

    tri2d_front
    #(
        .MIN_REFERENCES (MIN_REFERENCES)
    )
    u_front
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (start && !busy),
        .ref0_x          (ref0_x),
        .ref0_y          (ref0_y),
        .dist0           (dist0),
        .ref1_x          (ref1_x),
        .ref1_y          (ref1_y),
        .dist1           (dist1),
        .ref2_x          (ref2_x),
        .ref2_y          (ref2_y),
        .dist2           (dist2),
        .reference_count (reference_count),
        .ctrl            (front_ctrl),
        .num_x           (num_x),
        .num_y           (num_y),
        .det             (det)
    );

    tri2d_div u_div_x
    (
        .clk   (clk),
        .num   (num_x),
        .den   (det),
        .coord (qx),
        .sat   (sat_x)
    );

    tri2d_div u_div_y
    (
        .clk   (clk),
        .num   (num_y),
        .den   (det),
        .coord (qy),
        .sat   (sat_y)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DIV_LAT; i++)
            begin
                ctrl_dly_reg[i] <= '0;
            end
        end
        else
        begin
            ctrl_dly_reg[0] <= front_ctrl;
            for (int i = 1; i < DIV_LAT; i++)
            begin
                ctrl_dly_reg[i] <= ctrl_dly_reg[i-1];
            end
        end
    end

    assign tail = ctrl_dly_reg[DIV_LAT-1];

    // Too few references wins over everything, since the coordinates are then meaningless.
    // A zero determinant comes next; the divider output is garbage in that case and is dropped.
    always_comb
    begin
        done_next = tail.valid;
        priority if (tail.few)
        begin
            status_next = tri2d_pkg::ST_FEW;
            pos_x_next  = '0;
            pos_y_next  = '0;
        end
        else if (tail.sing)
        begin
            status_next = tri2d_pkg::ST_SINGULAR;
            pos_x_next  = '0;
            pos_y_next  = '0;
        end
        else if (sat_x || sat_y)
        begin
            status_next = tri2d_pkg::ST_SATURATED;
            pos_x_next  = qx;
            pos_y_next  = qy;
        end
        else
        begin
            status_next = tri2d_pkg::ST_SOLVED;
            pos_x_next  = qx;
            pos_y_next  = qy;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_x_reg  <= pos_x_next;
        pos_y_reg  <= pos_y_next;
        status_reg <= status_next;
    end

    assign done   = done_reg;
    assign pos_x  = pos_x_reg;
    assign pos_y  = pos_y_reg;
    assign status = status_reg;

    assign reject_seen = done && (status == tri2d_pkg::ST_FEW ||
                                  status == tri2d_pkg::ST_SINGULAR);

    // Every result traces back to exactly one request a fixed latency earlier.
    `TRI2D_ASSERT_IMPL(a_done_has_request, done, $past(start && !busy, tri2d_pkg::TOTAL_LAT))
    // The control delay line and the output stage stay in step.
    `TRI2D_ASSERT_NEXT(a_tail_gives_done, tail.valid, done)
    // Rejected solves report the origin.
    `TRI2D_ASSERT_IMPL(a_reject_zero, reject_seen, pos_x == '0 && pos_y == '0)

endmodule

[sv/tri2d_front.sv]
// Front half of the solver: line coefficients, determinant and both Cramer numerators.
// Depends on tri2d_pkg; seven register stages.
module tri2d_front
#(
    parameter logic [tri2d_pkg::W_CNT-1:0] MIN_REFERENCES = tri2d_pkg::MIN_REFERENCES
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic signed [tri2d_pkg::W_CRD-1:0]  ref0_x,
    input  logic signed [tri2d_pkg::W_CRD-1:0]  ref0_y,
    input  logic        [tri2d_pkg::W_DIST-1:0] dist0,
    input  logic signed [tri2d_pkg::W_CRD-1:0]  ref1_x,
    input  logic signed [tri2d_pkg::W_CRD-1:0]  ref1_y,
    input  logic        [tri2d_pkg::W_DIST-1:0] dist1,
    input  logic signed [tri2d_pkg::W_CRD-1:0]  ref2_x,
    input  logic signed [tri2d_pkg::W_CRD-1:0]  ref2_y,
    input  logic        [tri2d_pkg::W_DIST-1:0] dist2,
    input  logic        [tri2d_pkg::W_CNT-1:0]  reference_count,
    output tri2d_pkg::ctrl_t                    ctrl,
    output logic signed [tri2d_pkg::W_NUM-1:0]  num_x,
    output logic signed [tri2d_pkg::W_NUM-1:0]  num_y,
    output logic signed [tri2d_pkg::W_DET-1:0]  det
);

    tri2d_pkg::ctrl_t c0_reg, c1_reg, c2_reg, c3_reg, c4_reg, c5_reg, c6_reg;

    // Stage 0: captured request.
    logic signed [tri2d_pkg::W_CRD-1:0]  x0_reg, y0_reg, x1_reg, y1_reg, x2_reg, y2_reg;
    logic        [tri2d_pkg::W_DIST-1:0] d0_reg, d1_reg, d2_reg;

    // Stage 1: coefficient differences and squares.
    logic signed [tri2d_pkg::W_DIFF-1:0] a1_reg, b1_reg, dd1_reg, e1_reg;
    logic signed [tri2d_pkg::W_SQ-1:0]   sx0_reg, sx1_reg, sx2_reg, sy0_reg, sy1_reg, sy2_reg;
    logic        [tri2d_pkg::W_SQ-1:0]   sd0_reg, sd1_reg, sd2_reg;
    logic signed [tri2d_pkg::W_DIFF-1:0] a_next, b_next, dd_next, e_next;
    logic signed [tri2d_pkg::W_SQ-1:0]   sx0_next, sx1_next, sx2_next;
    logic signed [tri2d_pkg::W_SQ-1:0]   sy0_next, sy1_next, sy2_next;
    logic        [tri2d_pkg::W_SQ-1:0]   sd0_next, sd1_next, sd2_next;

    // Stage 2: pairwise square differences and determinant products.
    logic signed [tri2d_pkg::W_DIFF-1:0] a2_reg, b2_reg, dd2_reg, e2_reg;
    logic signed [tri2d_pkg::W_CF-1:0]   cd_reg, cx_reg, cy_reg, fd_reg, fx_reg, fy_reg;
    logic signed [tri2d_pkg::W_PP-1:0]   ae_reg, bd_reg;

    // Stage 3: right-hand sides and determinant.
    logic signed [tri2d_pkg::W_DIFF-1:0] a3_reg, b3_reg, dd3_reg, e3_reg;
    logic signed [tri2d_pkg::W_CF-1:0]   c3_val_reg, f3_val_reg;
    logic signed [tri2d_pkg::W_DET-1:0]  det3_reg, det4_reg, det5_reg, det6_reg;

    // Stage 4: split partial products.
    logic signed [tri2d_pkg::W_PP-1:0]   ce_hi_reg, ce_lo_reg, fb_hi_reg, fb_lo_reg;
    logic signed [tri2d_pkg::W_PP-1:0]   af_hi_reg, af_lo_reg, cdp_hi_reg, cdp_lo_reg;

    // Stage 5: full products.
    logic signed [tri2d_pkg::W_PROD-1:0] ce_reg, fb_reg, af_reg, cdp_reg;

    // Stage 6: numerators.
    logic signed [tri2d_pkg::W_NUM-1:0]  nx_reg, ny_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c0_reg <= '0;
            c1_reg <= '0;
            c2_reg <= '0;
            c3_reg <= '0;
            c4_reg <= '0;
            c5_reg <= '0;
            c6_reg <= '0;
        end
        else
        begin
            c0_reg <= '{valid: in_valid,
                        few:   (reference_count < MIN_REFERENCES),
                        sing:  1'b0};
            c1_reg <= c0_reg;
            c2_reg <= c1_reg;
            c3_reg <= c2_reg;
            c4_reg <= c3_reg;
            c5_reg <= c4_reg;
            c6_reg <= '{valid: c5_reg.valid,
                        few:   c5_reg.few,
                        sing:  (det5_reg == '0)};
        end
    end

    always_comb
    begin
        a_next   = {34'(x1_reg) - 34'(x0_reg)} <<< 1;
        b_next   = {34'(y1_reg) - 34'(y0_reg)} <<< 1;
        dd_next  = {34'(x2_reg) - 34'(x1_reg)} <<< 1;
        e_next   = {34'(y2_reg) - 34'(y1_reg)} <<< 1;
        sx0_next = x0_reg * x0_reg;
        sx1_next = x1_reg * x1_reg;
        sx2_next = x2_reg * x2_reg;
        sy0_next = y0_reg * y0_reg;
        sy1_next = y1_reg * y1_reg;
        sy2_next = y2_reg * y2_reg;
        sd0_next = 64'(d0_reg) * 64'(d0_reg);
        sd1_next = 64'(d1_reg) * 64'(d1_reg);
        sd2_next = 64'(d2_reg) * 64'(d2_reg);
    end

    always_ff @(posedge clk)
    begin
        x0_reg  <= ref0_x;
        y0_reg  <= ref0_y;
        d0_reg  <= dist0;
        x1_reg  <= ref1_x;
        y1_reg  <= ref1_y;
        d1_reg  <= dist1;
        x2_reg  <= ref2_x;
        y2_reg  <= ref2_y;
        d2_reg  <= dist2;

        a1_reg  <= a_next;
        b1_reg  <= b_next;
        dd1_reg <= dd_next;
        e1_reg  <= e_next;
        sx0_reg <= sx0_next;
        sx1_reg <= sx1_next;
        sx2_reg <= sx2_next;
        sy0_reg <= sy0_next;
        sy1_reg <= sy1_next;
        sy2_reg <= sy2_next;
        sd0_reg <= sd0_next;
        sd1_reg <= sd1_next;
        sd2_reg <= sd2_next;

        a2_reg  <= a1_reg;
        b2_reg  <= b1_reg;
        dd2_reg <= dd1_reg;
        e2_reg  <= e1_reg;
        cd_reg  <= $signed({1'b0, sd0_reg}) - $signed({1'b0, sd1_reg});
        cx_reg  <= 65'(sx1_reg) - 65'(sx0_reg);
        cy_reg  <= 65'(sy1_reg) - 65'(sy0_reg);
        fd_reg  <= $signed({1'b0, sd1_reg}) - $signed({1'b0, sd2_reg});
        fx_reg  <= 65'(sx2_reg) - 65'(sx1_reg);
        fy_reg  <= 65'(sy2_reg) - 65'(sy1_reg);
        ae_reg  <= a1_reg * e1_reg;
        bd_reg  <= b1_reg * dd1_reg;

        a3_reg     <= a2_reg;
        b3_reg     <= b2_reg;
        dd3_reg    <= dd2_reg;
        e3_reg     <= e2_reg;
        c3_val_reg <= cd_reg + cx_reg + cy_reg;
        f3_val_reg <= fd_reg + fx_reg + fy_reg;
        det3_reg   <= 68'(ae_reg) - 68'(bd_reg);

        // The 65-bit sides are split into a signed upper part and an unsigned lower word.
        ce_hi_reg  <= $signed(c3_val_reg[64:32]) * e3_reg;
        ce_lo_reg  <= $signed({1'b0, c3_val_reg[31:0]}) * e3_reg;
        fb_hi_reg  <= $signed(f3_val_reg[64:32]) * b3_reg;
        fb_lo_reg  <= $signed({1'b0, f3_val_reg[31:0]}) * b3_reg;
        af_hi_reg  <= $signed(f3_val_reg[64:32]) * a3_reg;
        af_lo_reg  <= $signed({1'b0, f3_val_reg[31:0]}) * a3_reg;
        cdp_hi_reg <= $signed(c3_val_reg[64:32]) * dd3_reg;
        cdp_lo_reg <= $signed({1'b0, c3_val_reg[31:0]}) * dd3_reg;
        det4_reg   <= det3_reg;

        ce_reg   <= $signed({ce_hi_reg[65:0], 32'b0}) + 98'(ce_lo_reg);
        fb_reg   <= $signed({fb_hi_reg[65:0], 32'b0}) + 98'(fb_lo_reg);
        af_reg   <= $signed({af_hi_reg[65:0], 32'b0}) + 98'(af_lo_reg);
        cdp_reg  <= $signed({cdp_hi_reg[65:0], 32'b0}) + 98'(cdp_lo_reg);
        det5_reg <= det4_reg;

        nx_reg   <= 99'(ce_reg) - 99'(fb_reg);
        ny_reg   <= 99'(af_reg) - 99'(cdp_reg);
        det6_reg <= det5_reg;
    end

    assign ctrl  = c6_reg;
    assign num_x = nx_reg;
    assign num_y = ny_reg;
    assign det   = det6_reg;

endmodule

[sv/tri2d_div.sv]
// Pipelined signed divider with round-to-nearest and 32-bit saturation, one quotient bit per stage.
// Depends on tri2d_pkg.
module tri2d_div
(
    input  logic                               clk,
    input  logic signed [tri2d_pkg::W_NUM-1:0] num,
    input  logic signed [tri2d_pkg::W_DET-1:0] den,
    output logic        [tri2d_pkg::W_CRD-1:0] coord,
    output logic                               sat
);

    localparam int QB = tri2d_pkg::Q_BITS;

    logic                               neg0_reg, neg1_reg;
    logic        [tri2d_pkg::W_ABSN-1:0] an_reg;
    logic        [tri2d_pkg::W_DET-1:0]  ad_reg;
    logic        [tri2d_pkg::W_N-1:0]    n1_reg;
    logic        [tri2d_pkg::W_DV-1:0]   dv1_reg;

    logic        [tri2d_pkg::W_N-1:0]    rem_reg [0:QB];
    logic        [tri2d_pkg::W_DV-1:0]   dv_reg  [0:QB];
    logic        [QB-1:0]                q_reg   [0:QB];
    logic                                neg_reg [0:QB];
    logic                                ovf_reg [0:QB];

    logic        [tri2d_pkg::W_CRD-1:0]  coord_reg, coord_next;
    logic                                sat_reg, sat_next;

    always_ff @(posedge clk)
    begin
        // Magnitudes and result sign.
        neg0_reg <= num[tri2d_pkg::W_NUM-1] ^ den[tri2d_pkg::W_DET-1];
        an_reg   <= tri2d_pkg::W_ABSN'(num[tri2d_pkg::W_NUM-1] ? -num : num);
        ad_reg   <= den[tri2d_pkg::W_DET-1] ? -den : den;

        // Rounding: (2|n| + |d|) / (2|d|).
        neg1_reg <= neg0_reg;
        n1_reg   <= {2'b0, an_reg, 1'b0} + tri2d_pkg::W_N'(ad_reg);
        dv1_reg  <= {ad_reg, 1'b0};

        // A quotient of 2^32 or more clamps whatever the sign.
        rem_reg[0] <= n1_reg;
        dv_reg[0]  <= dv1_reg;
        q_reg[0]   <= '0;
        neg_reg[0] <= neg1_reg;
        ovf_reg[0] <= (n1_reg >= {dv1_reg, 32'b0});
    end

    for (genvar k = 0; k < QB; k++)
    begin : g_step
        logic [tri2d_pkg::W_N-1:0] sh;
        logic                      ge;

        assign sh = tri2d_pkg::W_N'(dv_reg[k]) << (QB - 1 - k);
        assign ge = (rem_reg[k] >= sh);

        always_ff @(posedge clk)
        begin
            rem_reg[k+1] <= ge ? (rem_reg[k] - sh) : rem_reg[k];
            dv_reg[k+1]  <= dv_reg[k];
            q_reg[k+1]   <= {q_reg[k][QB-2:0], ge};
            neg_reg[k+1] <= neg_reg[k];
            ovf_reg[k+1] <= ovf_reg[k];
        end
    end

    always_comb
    begin
        if (neg_reg[QB])
        begin
            sat_next   = ovf_reg[QB] || (q_reg[QB] > tri2d_pkg::COORD_MIN);
            coord_next = sat_next ? tri2d_pkg::COORD_MIN : (~q_reg[QB] + 32'd1);
        end
        else
        begin
            sat_next   = ovf_reg[QB] || q_reg[QB][QB-1];
            coord_next = sat_next ? tri2d_pkg::COORD_MAX : q_reg[QB];
        end
    end

    always_ff @(posedge clk)
    begin
        coord_reg <= coord_next;
        sat_reg   <= sat_next;
    end

    assign coord = coord_reg;
    assign sat   = sat_reg;

endmodule

[verif/testbench.sv]
// Self-checking testbench for trilateration_2d_solver: directed and random requests.
// Predicts each position with exact wide integer arithmetic and checks every done strobe.
// Depends on tri2d_pkg and the solver RTL only.
`timescale 1ns / 1ps

module testbench;

    // One predicted solver answer.
    typedef struct {
        logic signed [tri2d_pkg::W_CRD-1:0] px;
        logic signed [tri2d_pkg::W_CRD-1:0] py;
        tri2d_pkg::status_t                 st;
    } fix_t;

    // One request as it is driven onto the ports.
    typedef struct {
        logic signed [tri2d_pkg::W_CRD-1:0]  x0, y0, x1, y1, x2, y2;
        logic        [tri2d_pkg::W_DIST-1:0] d0, d1, d2;
        logic        [tri2d_pkg::W_CNT-1:0]  cnt;
    } beacons_t;

    localparam int STALL_LIMIT = 5000;
    localparam int DRAIN_CYCLES = tri2d_pkg::TOTAL_LAT + 20;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic signed [tri2d_pkg::W_CRD-1:0]  ref0_x, ref0_y, ref1_x, ref1_y, ref2_x, ref2_y;
    logic        [tri2d_pkg::W_DIST-1:0] dist0, dist1, dist2;
    logic        [tri2d_pkg::W_CNT-1:0]  reference_count;
    logic done;
    logic signed [tri2d_pkg::W_CRD-1:0] pos_x, pos_y;
    logic [1:0] status;

    // Predicted positions waiting for their done strobe, oldest first.
    fix_t pending_fixes[$];
    int   error_count;
    int   idle_cycles;
    bit   accepted_now;

    trilateration_2d_solver dut
    (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .ref0_x(ref0_x),
        .ref0_y(ref0_y),
        .dist0(dist0),
        .ref1_x(ref1_x),
        .ref1_y(ref1_y),
        .dist1(dist1),
        .ref2_x(ref2_x),
        .ref2_y(ref2_y),
        .dist2(dist2),
        .reference_count(reference_count),
        .done(done),
        .pos_x(pos_x),
        .pos_y(pos_y),
        .status(status)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Round-to-nearest (ties away from zero) quotient of num/det, clamped to 32 bits.
    function automatic logic signed [tri2d_pkg::W_CRD-1:0] divide_coord(
        input logic signed [127:0] num, input logic signed [127:0] det, inout bit clamped);
        logic [127:0] an, ad, q;
        bit neg;
        an = (num < 0) ? -num : num;
        ad = (det < 0) ? -det : det;
        neg = (num < 0) != (det < 0);
        q = ((an << 1) + ad) / (ad << 1);
        if (!neg)
        begin
            if (q > 128'h7FFF_FFFF)
            begin
                clamped = 1'b1;
                return tri2d_pkg::COORD_MAX;
            end
            return q[31:0];
        end
        if (q > 128'h8000_0000)
        begin
            clamped = 1'b1;
            return tri2d_pkg::COORD_MIN;
        end
        return -q[31:0];
    endfunction

    // Subtract the circle equations pairwise and solve the 2x2 system by Cramer's rule.
    function automatic fix_t locate(input beacons_t b);
        logic signed [127:0] x0, y0, x1, y1, x2, y2, d0, d1, d2;
        logic signed [127:0] ca, cb, cd, ce, cc, cf, det, nx, ny;
        fix_t r;
        bit clamped;
        r.px = '0;
        r.py = '0;
        clamped = 1'b0;
        if (b.cnt < tri2d_pkg::MIN_REFERENCES)
        begin
            r.st = tri2d_pkg::ST_FEW;
            return r;
        end
        x0 = b.x0; y0 = b.y0; x1 = b.x1; y1 = b.y1; x2 = b.x2; y2 = b.y2;
        d0 = $signed({1'b0, b.d0});
        d1 = $signed({1'b0, b.d1});
        d2 = $signed({1'b0, b.d2});
        ca = 2 * (x1 - x0);
        cb = 2 * (y1 - y0);
        cd = 2 * (x2 - x1);
        ce = 2 * (y2 - y1);
        cc = d0 * d0 - d1 * d1 - x0 * x0 + x1 * x1 - y0 * y0 + y1 * y1;
        cf = d1 * d1 - d2 * d2 - x1 * x1 + x2 * x2 - y1 * y1 + y2 * y2;
        det = ca * ce - cb * cd;
        if (det == 0)
        begin
            r.st = tri2d_pkg::ST_SINGULAR;
            return r;
        end
        nx = cc * ce - cf * cb;
        ny = ca * cf - cc * cd;
        r.px = divide_coord(nx, det, clamped);
        r.py = divide_coord(ny, det, clamped);
        r.st = clamped ? tri2d_pkg::ST_SATURATED : tri2d_pkg::ST_SOLVED;
        return r;
    endfunction

    // Drive one request and hold it until the solver takes it at a rising edge.
    // Start is left high; a following gap or request decides its next value.
    task automatic send_request(input beacons_t b);
        ref0_x <= b.x0; ref0_y <= b.y0; dist0 <= b.d0;
        ref1_x <= b.x1; ref1_y <= b.y1; dist1 <= b.d1;
        ref2_x <= b.x2; ref2_y <= b.y2; dist2 <= b.d2;
        reference_count <= b.cnt;
        start <= 1'b1;
        forever
        begin
            // Busy only changes at rising edges, so the falling edge sees the value
            // that the next rising edge will act on.
            @(negedge clk);
            if (!busy)
            begin
                @(posedge clk);
                pending_fixes.push_back(locate(b));
                accepted_now = 1'b1;
                break;
            end
            @(posedge clk);
        end
    endtask

    // Random gap between requests: mostly none or short, now and then long.
    task automatic request_gap();
        int n;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: n = 0;
            5, 6, 7, 8:    n = $urandom_range(1, 3);
            default:       n = $urandom_range(10, 40);
        endcase
        if (n > 0)
        begin
            start <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    function automatic beacons_t make_beacons(
        input int x0, y0, x1, y1, x2, y2, input int d0, d1, d2, input int cnt);
        beacons_t b;
        b.x0 = x0; b.y0 = y0; b.x1 = x1; b.y1 = y1; b.x2 = x2; b.y2 = y2;
        b.d0 = tri2d_pkg::W_DIST'(d0);
        b.d1 = tri2d_pkg::W_DIST'(d1);
        b.d2 = tri2d_pkg::W_DIST'(d2);
        b.cnt = tri2d_pkg::W_CNT'(cnt);
        return b;
    endfunction

    // Too few references, singular layouts, coordinate extremes and clamping.
    task automatic test_directed();
        localparam int ONE = 1 << 16;
        int lo, hi;
        lo = 32'h8000_0000;
        hi = 32'h7FFF_FFFF;
        // Count below three reports too few references, whatever the points are.
        send_request(make_beacons(0, 0, ONE, 0, 0, ONE, ONE, ONE, ONE, 0));
        send_request(make_beacons(hi, lo, 5, 7, lo, hi, 31'h7FFF_FFFF, 0, 9, 2));
        // A small well-posed triangle at the minimum and the maximum count.
        send_request(make_beacons(0, 0, 4 * ONE, 0, 0, 4 * ONE,
                                  ONE * 5 / 2, ONE * 2, ONE * 3, 3));
        send_request(make_beacons(ONE, ONE, -3 * ONE, 2 * ONE, 5 * ONE, -4 * ONE,
                                  3 * ONE, 4 * ONE, 5 * ONE, 63));
        // Collinear and fully coincident references give a zero determinant.
        send_request(make_beacons(0, 0, ONE, ONE, 2 * ONE, 2 * ONE, ONE, ONE, ONE, 3));
        send_request(make_beacons(7, 7, 7, 7, 7, 7, 0, 0, 0, 3));
        send_request(make_beacons(lo, lo, lo, lo, hi, hi, 0, 31'h7FFF_FFFF, 0, 3));
        // Extreme corners with extreme distances.
        send_request(make_beacons(lo, lo, hi, lo, lo, hi,
                                  31'h7FFF_FFFF, 0, 31'h7FFF_FFFF, 3));
        send_request(make_beacons(hi, hi, lo, hi, hi, lo,
                                  0, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 3));
        send_request(make_beacons(lo, hi, hi, hi, hi, lo, 0, 0, 0, 63));
        // A tiny triangle with large distances pushes the answer out of range.
        send_request(make_beacons(0, 0, 1, 0, 0, 1, 31'h7FFF_FFFF, 0, 0, 3));
        send_request(make_beacons(0, 0, 1, 0, 0, 1, 0, 31'h7FFF_FFFF, 0, 3));
        send_request(make_beacons(0, 0, 1, 0, 0, 1, 0, 0, 31'h7FFF_FFFF, 3));
        send_request(make_beacons(0, 0, -1, 1, 1, 0, 31'h4000_0000, 0, 5, 3));
        // All-zero request and all-ones count.
        send_request(make_beacons(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_request(make_beacons(-1, -1, 0, -1, -1, 0, 1, 1, 1, 63));
    endtask

    // Random request: mostly real geometry around a hidden position, some raw noise.
    function automatic beacons_t random_beacons();
        beacons_t b;
        int scale, px, py, k;
        int xs[3], ys[3];
        longint dx, dy;
        logic [tri2d_pkg::W_DIST-1:0] ds[3];
        if ($urandom_range(0, 3) == 0)
        begin
            b.x0 = $urandom; b.y0 = $urandom; b.x1 = $urandom;
            b.y1 = $urandom; b.x2 = $urandom; b.y2 = $urandom;
            b.d0 = tri2d_pkg::W_DIST'($urandom);
            b.d1 = tri2d_pkg::W_DIST'($urandom);
            b.d2 = tri2d_pkg::W_DIST'($urandom);
            b.cnt = tri2d_pkg::W_CNT'($urandom);
            return b;
        end
        // Pick a span from +/-2^4 up to +/-2^29, most of the coordinate range.
        scale = $urandom_range(4, 29);
        px = $signed($urandom) >>> (31 - scale);
        py = $signed($urandom) >>> (31 - scale);
        for (k = 0; k < 3; k++)
        begin
            xs[k] = $signed($urandom) >>> (31 - scale);
            ys[k] = $signed($urandom) >>> (31 - scale);
            dx = longint'(xs[k]) - px;
            dy = longint'(ys[k]) - py;
            if (dx < 0) dx = -dx;
            if (dy < 0) dy = -dy;
            // Octagonal estimate of the distance, with a little measurement noise.
            dx = (dx > dy) ? dx + dy / 2 : dy + dx / 2;
            dx = dx + $urandom_range(0, 15);
            ds[k] = (dx > 64'h7FFF_FFFF) ? 31'h7FFF_FFFF : dx[tri2d_pkg::W_DIST-1:0];
        end
        // Now and then make two references collinear with the third.
        if ($urandom_range(0, 15) == 0)
        begin
            xs[2] = xs[1] + (xs[1] - xs[0]) / 2;
            ys[2] = ys[1] + (ys[1] - ys[0]) / 2;
        end
        b.x0 = xs[0]; b.y0 = ys[0]; b.x1 = xs[1];
        b.y1 = ys[1]; b.x2 = xs[2]; b.y2 = ys[2];
        b.d0 = ds[0]; b.d1 = ds[1]; b.d2 = ds[2];
        b.cnt = tri2d_pkg::W_CNT'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 2)
                                                             : $urandom_range(3, 63));
        return b;
    endfunction

    task automatic test_random(input int count);
        int i;
        for (i = 0; i < count; i++)
        begin
            send_request(random_beacons());
            // Long back-to-back bursts leave the pipeline full for a while.
            if (i % 100 >= 40)
                request_gap();
        end
    endtask

    // Compare each done strobe with the oldest prediction.
    always @(negedge clk)
    begin
        fix_t want;
        if (rst_n && done)
        begin
            if (pending_fixes.size() == 0)
            begin
                $error("unexpected result: pos_x %0d pos_y %0d status %0d",
                       pos_x, pos_y, status);
                error_count++;
            end
            else
            begin
                want = pending_fixes.pop_front();
                if (pos_x !== want.px)
                begin
                    $error("pos_x: expected %0d, got %0d", want.px, pos_x);
                    error_count++;
                end
                if (pos_y !== want.py)
                begin
                    $error("pos_y: expected %0d, got %0d", want.py, pos_y);
                    error_count++;
                end
                if (status !== want.st)
                begin
                    $error("status: expected %0d, got %0d", want.st, status);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: stop the run if nothing moves for too long.
    always @(posedge clk)
    begin
        if (accepted_now || (rst_n && done))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        accepted_now = 1'b0;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("FAIL trilateration_2d_solver");
            $finish;
        end
    end

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        start = 1'b0;
        ref0_x = '0; ref0_y = '0; dist0 = '0;
        ref1_x = '0; ref1_y = '0; dist1 = '0;
        ref2_x = '0; ref2_y = '0; dist2 = '0;
        reference_count = '0;
        error_count = 0;
        idle_cycles = 0;
        accepted_now = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random(450);
        start <= 1'b0;

        // Drain: every prediction must be matched, then a quiet tail for strays.
        while (pending_fixes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("PASS trilateration_2d_solver");
        else
            $display("FAIL trilateration_2d_solver");
        $finish;
    end

endmodule

[files.f]
+incdir+sv
sv/tri2d_pkg.sv
sv/tri2d_front.sv
sv/tri2d_div.sv
sv/trilateration_2d_solver.sv
verif/testbench.sv
